// ===== rtl/core/date_range_day_span_tracker_defines.svh =====
// Assertion macros for the date span tracker.
// Used by the queue and the back end; needs clk and arst_n in scope.
`ifndef DATE_RANGE_DAY_SPAN_TRACKER_DEFINES_SVH
`define DATE_RANGE_DAY_SPAN_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define DRT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("date span tracker: assertion failed");
`define DRT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("date span tracker: assertion failed");
`else
`define DRT_ASSERT(lbl, prop)
`define DRT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/drt_pkg.sv =====
// Shared types and tables for the date span tracker.
// No dependencies; imported by every module of the block.
`default_nettype none
package drt_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int NUM_W   = 22;

	// One classified date travelling from the front end to the back end.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               first_date;
		logic               ok;
		logic [NUM_W-1:0]   number;
	} entry_t;

	// Days in the year before the first of the given month (non-leap year).
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/drt_front.sv =====
// Front end: accepts dates, checks them and computes their day numbers.
// Two pipeline stages; depends on drt_pkg.
`default_nettype none
module drt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [drt_pkg::DAY_W-1:0]   day,
	input  logic [drt_pkg::MONTH_W-1:0] month,
	input  logic [drt_pkg::YEAR_W-1:0]  year,
	input  logic                        first_date,
	output logic                        push_valid,
	input  logic                        push_ready,
	output drt_pkg::entry_t             push_data
);
	import drt_pkg::*;

	// floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;
	localparam int          PROD_W    = YEAR_W + 13;
	localparam int          Q_W       = 8;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0] LEN_LEAP_FEB = 5'd29;
	localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
	localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
	localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

	logic                en;
	logic [PROD_W-1:0]   prod;

	logic                v_s1;
	logic [DAY_W-1:0]    day_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [YEAR_W-1:0]   year_s1;
	logic                first_s1;
	logic [Q_W-1:0]      q100_s1;

	logic [YEAR_W-1:0]   rem100;
	logic                rem_zero;
	logic                leap;
	logic [DAY_W-1:0]    mlen;
	logic                ok;
	logic [YEAR_W-1:0]   p;
	logic [Q_W-1:0]      p100;
	logic [NUM_W-1:0]    base;

	logic                v_s2;
	logic [DAY_W-1:0]    day_s2;
	logic [MONTH_W-1:0]  month_s2;
	logic [YEAR_W-1:0]   year_s2;
	logic                first_s2;
	logic                ok_s2;
	logic                leap_add_s2;
	logic [NUM_W-1:0]    base_s2;

	// hold the whole pipe while the queue refuses the last stage
	assign en       = !v_s2 || push_ready;
	assign in_ready = en;

	assign prod = PROD_W'(year) * PROD_W'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1      <= day;
			month_s1    <= month;
			year_s1     <= year;
			first_s1    <= first_date;
			q100_s1     <= prod[RECIP_SH +: Q_W];
			day_s2      <= day_s1;
			month_s2    <= month_s1;
			year_s2     <= year_s1;
			first_s2    <= first_s1;
			ok_s2       <= ok;
			leap_add_s2 <= leap && (month_s1 > MONTH_FEB);
			base_s2     <= base;
		end
	end

	always_comb begin
		rem100   = year_s1 - ({{(YEAR_W-Q_W){1'b0}}, q100_s1} * 14'd100);
		rem_zero = (rem100 == '0);
		leap     = (!rem_zero && (year_s1[1:0] == 2'b00)) ||
		           (rem_zero && (q100_s1[1:0] == 2'b00));
		case (month_s1)
			4'd2:    mlen = leap ? LEN_LEAP_FEB : LEN_FEB;
			4'd4,
			4'd6,
			4'd9,
			4'd11:   mlen = LEN_SHORT;
			default: mlen = LEN_LONG;
		endcase
		ok = (year_s1 != '0) && (year_s1 <= YEAR_MAX) &&
		     (month_s1 != '0) && (month_s1 <= MONTH_DEC) &&
		     (day_s1 != '0) && (day_s1 <= mlen);
		// days before 1 Jan of this year: p = y - 1, (y-1)/100 from y/100
		p    = year_s1 - 14'd1;
		p100 = q100_s1 - Q_W'(rem_zero);
		base = NUM_W'(p) * NUM_W'(365) + NUM_W'(p[YEAR_W-1:2]) - NUM_W'(p100)
		     + NUM_W'(p100[Q_W-1:2]);
	end

	assign push_valid           = v_s2;
	assign push_data.day        = day_s2;
	assign push_data.month      = month_s2;
	assign push_data.year       = year_s2;
	assign push_data.first_date = first_s2;
	assign push_data.ok         = ok_s2;
	assign push_data.number     = base_s2 + NUM_W'(days_before(month_s2))
	                            + NUM_W'(leap_add_s2) + NUM_W'(day_s2);

endmodule
`default_nettype wire

// ===== rtl/core/drt_fifo.sv =====
// Short queue between front end and back end.
// Register array with read and write pointers; depends on drt_pkg.
`default_nettype none
`include "date_range_day_span_tracker_defines.svh"
module drt_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  drt_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output drt_pkg::entry_t pop_data
);
	import drt_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`DRT_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
	`DRT_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
	`DRT_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule
`default_nettype wire

// ===== rtl/core/drt_back.sv =====
// Back end: folds classified dates into the oldest/newest set and
// presents the result. State registers double as the output register.
`default_nettype none
`include "date_range_day_span_tracker_defines.svh"
module drt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  drt_pkg::entry_t             pop_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        date_ok,
	output logic [drt_pkg::DAY_W-1:0]   oldest_day,
	output logic [drt_pkg::MONTH_W-1:0] oldest_month,
	output logic [drt_pkg::YEAR_W-1:0]  oldest_year,
	output logic [drt_pkg::DAY_W-1:0]   newest_day,
	output logic [drt_pkg::MONTH_W-1:0] newest_month,
	output logic [drt_pkg::YEAR_W-1:0]  newest_year,
	output logic [drt_pkg::NUM_W-1:0]   span_days
);
	import drt_pkg::*;

	logic               out_valid_q;
	logic               date_ok_q;
	logic               have_any_q;
	logic [DAY_W-1:0]   low_day_q;
	logic [MONTH_W-1:0] low_month_q;
	logic [YEAR_W-1:0]  low_year_q;
	logic [DAY_W-1:0]   high_day_q;
	logic [MONTH_W-1:0] high_month_q;
	logic [YEAR_W-1:0]  high_year_q;
	logic [NUM_W-1:0]   low_number_q;
	logic [NUM_W-1:0]   high_number_q;
	logic               pop;
	logic               restart;

	// take the next entry only once the current result is gone
	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign restart   = pop_data.first_date || !have_any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			date_ok_q     <= 1'b0;
			have_any_q    <= 1'b0;
			low_day_q     <= '0;
			low_month_q   <= '0;
			low_year_q    <= '0;
			high_day_q    <= '0;
			high_month_q  <= '0;
			high_year_q   <= '0;
			low_number_q  <= '0;
			high_number_q <= '0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			date_ok_q   <= pop_data.ok;
			if (pop_data.ok) begin
				have_any_q <= 1'b1;
				if (restart || (pop_data.number < low_number_q)) begin
					low_day_q    <= pop_data.day;
					low_month_q  <= pop_data.month;
					low_year_q   <= pop_data.year;
					low_number_q <= pop_data.number;
				end
				if (restart || (pop_data.number > high_number_q)) begin
					high_day_q    <= pop_data.day;
					high_month_q  <= pop_data.month;
					high_year_q   <= pop_data.year;
					high_number_q <= pop_data.number;
				end
			end else if (pop_data.first_date) begin
				// drop the set
				have_any_q    <= 1'b0;
				low_day_q     <= '0;
				low_month_q   <= '0;
				low_year_q    <= '0;
				high_day_q    <= '0;
				high_month_q  <= '0;
				high_year_q   <= '0;
				low_number_q  <= '0;
				high_number_q <= '0;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign date_ok      = date_ok_q;
	assign oldest_day   = low_day_q;
	assign oldest_month = low_month_q;
	assign oldest_year  = low_year_q;
	assign newest_day   = high_day_q;
	assign newest_month = high_month_q;
	assign newest_year  = high_year_q;
	assign span_days    = high_number_q - low_number_q;

	`DRT_ASSERT(a_empty_zero, have_any_q || ((low_number_q == '0) && (high_number_q == '0)))
	`DRT_ASSERT(a_order, low_number_q <= high_number_q)
	`DRT_ASSERT_NEXT(a_hold_stalled, out_valid_q && !out_ready,
		$stable(low_number_q) && $stable(high_number_q) && $stable(date_ok_q))

endmodule
`default_nettype wire

// ===== rtl/core/date_range_day_span_tracker.sv =====
// Date span tracker: one Gregorian date in, one result out per date.
// Input channel: in_valid/in_ready with day, month, year and first_date.
//   first_date starts a new set; an invalid date with it empties the set.
// Output channel: out_valid/out_ready with date_ok, the oldest and newest
//   dates of the set and span_days, the day count between them.
// Throughput: one date per cycle while out_ready stays high. The limit is the
//   back end's compare-and-select on the stored oldest/newest day numbers.
// Path: an accepted date passes the two front stages, one queue slot and
//   the output register before its result is valid.
// Reset (arst_n low) empties the set and the queue; no item is in flight.
// When out_ready is low the result holds, the queue fills, and once the
//   front stages are blocked in_ready drops until the receiver resumes.
// QUEUE_DEPTH sets the entries between front and back end (2 or more).
`default_nettype none
module date_range_day_span_tracker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [drt_pkg::DAY_W-1:0]   day,
	input  logic [drt_pkg::MONTH_W-1:0] month,
	input  logic [drt_pkg::YEAR_W-1:0]  year,
	input  logic                        first_date,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        date_ok,
	output logic [drt_pkg::DAY_W-1:0]   oldest_day,
	output logic [drt_pkg::MONTH_W-1:0] oldest_month,
	output logic [drt_pkg::YEAR_W-1:0]  oldest_year,
	output logic [drt_pkg::DAY_W-1:0]   newest_day,
	output logic [drt_pkg::MONTH_W-1:0] newest_month,
	output logic [drt_pkg::YEAR_W-1:0]  newest_year,
	output logic [drt_pkg::NUM_W-1:0]   span_days
);
	import drt_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	drt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.day        (day),
		.month      (month),
		.year       (year),
		.first_date (first_date),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	drt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	drt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.date_ok      (date_ok),
		.oldest_day   (oldest_day),
		.oldest_month (oldest_month),
		.oldest_year  (oldest_year),
		.newest_day   (newest_day),
		.newest_month (newest_month),
		.newest_year  (newest_year),
		.span_days    (span_days)
	);

endmodule
`default_nettype wire

// ===== dv/drt_span_checker.sv =====
// Checker for the date span tracker: watches both channels, predicts each result
// from the accepted requests and compares it field by field.
// Depends on drt_pkg for the field widths.
`timescale 1ns / 1ps
module drt_span_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [drt_pkg::DAY_W-1:0]   day,
	input  logic [drt_pkg::MONTH_W-1:0] month,
	input  logic [drt_pkg::YEAR_W-1:0]  year,
	input  logic                        first_date,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        date_ok,
	input  logic [drt_pkg::DAY_W-1:0]   oldest_day,
	input  logic [drt_pkg::MONTH_W-1:0] oldest_month,
	input  logic [drt_pkg::YEAR_W-1:0]  oldest_year,
	input  logic [drt_pkg::DAY_W-1:0]   newest_day,
	input  logic [drt_pkg::MONTH_W-1:0] newest_month,
	input  logic [drt_pkg::YEAR_W-1:0]  newest_year,
	input  logic [drt_pkg::NUM_W-1:0]   span_days,
	output int                          error_count,
	output int                          results_pending
);
	import drt_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [DAY_W-1:0]   old_d;
		logic [MONTH_W-1:0] old_m;
		logic [YEAR_W-1:0]  old_y;
		logic [DAY_W-1:0]   new_d;
		logic [MONTH_W-1:0] new_m;
		logic [YEAR_W-1:0]  new_y;
		logic [NUM_W-1:0]   span;
	} span_result_t;

	span_result_t expected_spans[$];

	// Running set: oldest and newest dates with their day ordinals.
	bit                 set_open;
	logic [DAY_W-1:0]   lo_d, hi_d;
	logic [MONTH_W-1:0] lo_m, hi_m;
	logic [YEAR_W-1:0]  lo_y, hi_y;
	int                 lo_ord, hi_ord;

	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(input int y, input int m);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic int days_ahead(input int m);
		int r;
		case (m)
			2:       r = 31;
			3:       r = 59;
			4:       r = 90;
			5:       r = 120;
			6:       r = 151;
			7:       r = 181;
			8:       r = 212;
			9:       r = 243;
			10:      r = 273;
			11:      r = 304;
			12:      r = 334;
			default: r = 0;
		endcase
		return r;
	endfunction

	function automatic bit date_is_real(input int d, input int m, input int y);
		if (y < 1 || y > 9999)
			return 1'b0;
		if (m < 1 || m > 12)
			return 1'b0;
		return (d >= 1) && (d <= month_days(y, m));
	endfunction

	// Day 1 is 1 Jan of year 1.
	function automatic int ordinal_day(input int d, input int m, input int y);
		int p;
		int n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400 + days_ahead(m) + d;
		if (m > 2 && leap_year(y))
			n++;
		return n;
	endfunction

	task automatic clear_set();
		set_open = 1'b0;
		lo_d = '0; lo_m = '0; lo_y = '0; lo_ord = 0;
		hi_d = '0; hi_m = '0; hi_y = '0; hi_ord = 0;
	endtask

	task automatic predict_span(input int d, input int m, input int y, input bit f);
		span_result_t r;
		bit ok;
		int n;
		ok = date_is_real(d, m, y);
		if (ok) begin
			n = ordinal_day(d, m, y);
			if (f || !set_open) begin
				lo_d = DAY_W'(d); lo_m = MONTH_W'(m); lo_y = YEAR_W'(y); lo_ord = n;
				hi_d = DAY_W'(d); hi_m = MONTH_W'(m); hi_y = YEAR_W'(y); hi_ord = n;
				set_open = 1'b1;
			end else begin
				if (n < lo_ord) begin
					lo_d = DAY_W'(d); lo_m = MONTH_W'(m); lo_y = YEAR_W'(y); lo_ord = n;
				end
				if (n > hi_ord) begin
					hi_d = DAY_W'(d); hi_m = MONTH_W'(m); hi_y = YEAR_W'(y); hi_ord = n;
				end
			end
		end else if (f) begin
			clear_set();
		end
		r.ok    = ok;
		r.old_d = lo_d;
		r.old_m = lo_m;
		r.old_y = lo_y;
		r.new_d = hi_d;
		r.new_m = hi_m;
		r.new_y = hi_y;
		r.span  = NUM_W'(hi_ord - lo_ord);
		expected_spans.push_back(r);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_result_t want;
		if (!arst_n) begin
			clear_set();
			expected_spans.delete();
			results_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_spans.size() == 0) begin
					$error("result with no request outstanding");
					error_count++;
				end else begin
					want = expected_spans.pop_front();
					compare_field("date_ok", int'(want.ok), int'(date_ok));
					compare_field("oldest_day", int'(want.old_d), int'(oldest_day));
					compare_field("oldest_month", int'(want.old_m), int'(oldest_month));
					compare_field("oldest_year", int'(want.old_y), int'(oldest_year));
					compare_field("newest_day", int'(want.new_d), int'(newest_day));
					compare_field("newest_month", int'(want.new_m), int'(newest_month));
					compare_field("newest_year", int'(want.new_y), int'(newest_year));
					compare_field("span_days", int'(want.span), int'(span_days));
				end
			end
			if (in_valid && in_ready)
				predict_span(int'(day), int'(month), int'(year), first_date);
			results_pending <= expected_spans.size();
		end
	end

endmodule

// ===== dv/tb_date_range_day_span_tracker.sv =====
// Testbench top for the date span tracker: clock, reset, date requests and
// receiver back-pressure; the verdict comes from drt_span_checker.
// Depends on drt_pkg, the block and dv/drt_span_checker.sv.
`timescale 1ns / 1ps
module tb_date_range_day_span_tracker;
	import drt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1700;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [DAY_W-1:0]   day;
	logic [MONTH_W-1:0] month;
	logic [YEAR_W-1:0]  year;
	logic               first_date;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               date_ok;
	logic [DAY_W-1:0]   oldest_day;
	logic [MONTH_W-1:0] oldest_month;
	logic [YEAR_W-1:0]  oldest_year;
	logic [DAY_W-1:0]   newest_day;
	logic [MONTH_W-1:0] newest_month;
	logic [YEAR_W-1:0]  newest_year;
	logic [NUM_W-1:0]   span_days;

	int error_count;
	int results_pending;
	int cycle_count;
	int dates_sent;
	bit steady;

	date_range_day_span_tracker dut (.*);

	drt_span_checker span_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver stalls about a third of the time, except in the steady stretch.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(99) >= 35);
	end

	task automatic send_date(input int d, input int m, input int y, input bit f);
		while (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		day        <= d[DAY_W-1:0];
		month      <= m[MONTH_W-1:0];
		year       <= y[YEAR_W-1:0];
		first_date <= f;
		do
			@(posedge clk);
		while (!in_ready);
		dates_sent++;
	endtask

	initial begin
		int set_len;
		int base;
		int roll;
		int d;
		int m;
		int y;
		bit f;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		day        = '0;
		month      = '0;
		year       = '0;
		first_date = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set, range extremes, leap rules, month ends, set restarts.
		send_date(31, 2, 2020, 0);
		send_date(1, 1, 1, 1);
		send_date(31, 12, 9999, 0);
		send_date(29, 2, 2000, 0);
		send_date(29, 2, 1900, 0);
		send_date(29, 2, 2004, 0);
		send_date(29, 2, 2023, 0);
		send_date(28, 2, 1900, 0);
		send_date(0, 5, 2000, 0);
		send_date(10, 0, 2000, 0);
		send_date(10, 13, 2000, 0);
		send_date(10, 15, 2000, 0);
		send_date(10, 5, 0, 0);
		send_date(10, 5, 10000, 0);
		send_date(31, 15, 16383, 1);
		send_date(31, 4, 2000, 0);
		send_date(30, 4, 2000, 0);
		send_date(31, 12, 9999, 0);
		send_date(1, 1, 1, 0);
		send_date(0, 0, 0, 1);
		send_date(15, 6, 1500, 0);
		send_date(14, 6, 1500, 0);
		send_date(16, 6, 1500, 0);
		send_date(15, 6, 1500, 0);
		send_date(15, 6, 1500, 1);

		// Random sets of dates, mostly well formed, with some noise mixed in.
		while (dates_sent < RANDOM_ITEMS + 25) begin
			set_len = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
			base = $urandom_range(1, 9999);
			for (int k = 0; k < set_len; k++) begin
				steady = (dates_sent >= 700) && (dates_sent < 1000);
				roll = $urandom_range(99);
				if (roll < 8) begin
					send_date($urandom_range(0, 31), $urandom_range(0, 15),
						$urandom_range(0, 16383), 1'($urandom_range(1)));
				end else begin
					if ($urandom_range(19) == 0)
						y = $urandom_range(1) ? 1 : 9999;
					else if ($urandom_range(1))
						y = base + $urandom_range(0, 6) - 3;
					else
						y = $urandom_range(1, 9999);
					if (y < 1)
						y = 1;
					if (y > 9999)
						y = 9999;
					m = $urandom_range(1, 12);
					// Days past 28 hit the month-end and leap checks.
					d = ($urandom_range(9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
					if (roll < 11)
						d = 0;
					f = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
					send_date(d, m, y, f);
				end
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);

		while (results_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/drt_pkg.sv
rtl/core/drt_front.sv
rtl/core/drt_fifo.sv
rtl/core/drt_back.sv
rtl/core/date_range_day_span_tracker.sv
dv/drt_span_checker.sv
dv/tb_date_range_day_span_tracker.sv
